### design/ddsri_pkg.sv
// ----------------------------------------------------------------------------
// ddsri_pkg
// Types and constants shared by the synthesizer register interface.
// ----------------------------------------------------------------------------
package ddsri_pkg;

  localparam int WORD_BITS      = 16;
  localparam int CW_BITS        = 14;
  localparam int HALF_BITS      = 14;
  localparam int FREQ_BITS      = 28;
  localparam int PHASE_REG_BITS = 12;
  localparam int INDEX_BITS     = 12;
  localparam int MODE_BITS      = 2;

  // Control word bit positions
  localparam int CW_B28     = 13;
  localparam int CW_HLB     = 12;
  localparam int CW_FSEL    = 11;
  localparam int CW_PSEL    = 10;
  localparam int CW_RESET   = 8;
  localparam int CW_SLEEP1  = 7;
  localparam int CW_SLEEP12 = 6;
  localparam int CW_OPBITEN = 5;
  localparam int CW_DIV2    = 3;
  localparam int CW_MODE    = 1;

  localparam logic [CW_BITS-1:0] CW_RESET_VALUE = 14'h01C0;

  typedef enum logic {
    CMD_WORD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    SEL_CONTROL = 2'b00,
    SEL_FREQ0   = 2'b01,
    SEL_FREQ1   = 2'b10,
    SEL_PHASE   = 2'b11
  } sel_t;

  typedef enum logic [MODE_BITS-1:0] {
    WAVE_SINE        = 2'd0,
    WAVE_TRIANGLE    = 2'd1,
    WAVE_SQUARE_MSB  = 2'd2,
    WAVE_SQUARE_HALF = 2'd3
  } wave_t;

  typedef struct packed {
    logic                 cmd;
    logic [WORD_BITS-1:0] word;
  } item_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] phase_index;
    logic [MODE_BITS-1:0]  wave_mode;
    logic                  square_level;
    logic                  dac_enabled;
    logic                  running;
  } result_t;

endpackage

### design/ddsri_if.sv
// ----------------------------------------------------------------------------
// ddsri_req_if / ddsri_res_if
// Valid/ready channels for serial words and ticks, and for status results.
// ----------------------------------------------------------------------------
interface ddsri_req_if;
  logic                            valid;
  logic                            ready;
  logic                            cmd;
  logic [ddsri_pkg::WORD_BITS-1:0] word;

  modport source(output valid, output cmd, output word, input ready);
  modport sink(input valid, input cmd, input word, output ready);
endinterface

interface ddsri_res_if;
  logic                             valid;
  logic                             ready;
  logic [ddsri_pkg::INDEX_BITS-1:0] phase_index;
  logic [ddsri_pkg::MODE_BITS-1:0]  wave_mode;
  logic                             square_level;
  logic                             dac_enabled;
  logic                             running;

  modport source(output valid, output phase_index, output wave_mode, output square_level,
                 output dac_enabled, output running, input ready);
  modport sink(input valid, input phase_index, input wave_mode, input square_level,
               input dac_enabled, input running, output ready);
endinterface

### design/ddsri_in_stage.sv
// ----------------------------------------------------------------------------
// ddsri_in_stage
// Input register holding one accepted word or tick.
// ----------------------------------------------------------------------------
module ddsri_in_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic             advance,
  input  ddsri_pkg::item_t item_d,
  output logic             valid,
  output ddsri_pkg::item_t item
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_d;
    end
  end

endmodule

### design/ddsri_core.sv
// ----------------------------------------------------------------------------
// ddsri_core
// Register file, phase accumulator and square-wave logic; one item per step.
// ----------------------------------------------------------------------------
module ddsri_core #(
  parameter int ACC_BITS   = 28,
  parameter int PHASE_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  ddsri_pkg::item_t   item,
  output ddsri_pkg::result_t res
);

  logic [ddsri_pkg::CW_BITS-1:0]        control_word, control_word_next;
  logic [ddsri_pkg::FREQ_BITS-1:0]      freq [2];
  logic [ddsri_pkg::FREQ_BITS-1:0]      freq_next [2];
  logic [ddsri_pkg::PHASE_REG_BITS-1:0] phase [2];
  logic [ddsri_pkg::PHASE_REG_BITS-1:0] phase_next [2];
  logic                                 pending, pending_next;
  logic [ddsri_pkg::HALF_BITS-1:0]      held, held_next;
  logic [ACC_BITS-1:0]                  acc, acc_next;
  logic                                 toggle, toggle_next;
  logic                                 prev_msb, prev_msb_next;

  ddsri_pkg::sel_t                      sel;
  logic [ddsri_pkg::HALF_BITS-1:0]      data;
  logic                                 fidx;
  logic                                 toggle_base;
  logic                                 msb_next;
  logic [PHASE_BITS-1:0]                top_bits, offset, index;
  logic                                 psel;

  always_ff @(posedge clk) begin
    if (rst) begin
      control_word <= ddsri_pkg::CW_RESET_VALUE;
      freq[0]      <= '0;
      freq[1]      <= '0;
      phase[0]     <= '0;
      phase[1]     <= '0;
      pending      <= 1'b0;
      held         <= '0;
      acc          <= '0;
      toggle       <= 1'b0;
      prev_msb     <= 1'b0;
    end else if (step) begin
      control_word <= control_word_next;
      freq[0]      <= freq_next[0];
      freq[1]      <= freq_next[1];
      phase[0]     <= phase_next[0];
      phase[1]     <= phase_next[1];
      pending      <= pending_next;
      held         <= held_next;
      acc          <= acc_next;
      toggle       <= toggle_next;
      prev_msb     <= prev_msb_next;
    end
  end

  always_comb begin
    control_word_next = control_word;
    freq_next[0]      = freq[0];
    freq_next[1]      = freq[1];
    phase_next[0]     = phase[0];
    phase_next[1]     = phase[1];
    pending_next      = pending;
    held_next         = held;
    acc_next          = acc;
    toggle_next       = toggle;
    prev_msb_next     = prev_msb;
    toggle_base       = toggle;
    msb_next          = acc[ACC_BITS-1];
    sel               = ddsri_pkg::sel_t'(item.word[ddsri_pkg::WORD_BITS-1 -: 2]);
    data              = item.word[ddsri_pkg::HALF_BITS-1:0];
    fidx              = (sel == ddsri_pkg::SEL_FREQ1);

    if (item.cmd == ddsri_pkg::CMD_WORD) begin
      unique case (sel)
        ddsri_pkg::SEL_CONTROL: begin
          control_word_next = data;
          pending_next      = 1'b0;
        end
        ddsri_pkg::SEL_PHASE: begin
          phase_next[item.word[ddsri_pkg::HALF_BITS-1]] =
            item.word[ddsri_pkg::PHASE_REG_BITS-1:0];
        end
        ddsri_pkg::SEL_FREQ0, ddsri_pkg::SEL_FREQ1: begin
          if (control_word[ddsri_pkg::CW_B28]) begin
            if (!pending) begin
              held_next    = data;
              pending_next = 1'b1;
            end else begin
              freq_next[fidx] = {data, held};
              pending_next    = 1'b0;
            end
          end else if (control_word[ddsri_pkg::CW_HLB]) begin
            freq_next[fidx] = {data, freq[fidx][ddsri_pkg::HALF_BITS-1:0]};
          end else begin
            freq_next[fidx] = {freq[fidx][ddsri_pkg::FREQ_BITS-1 -: ddsri_pkg::HALF_BITS],
                               data};
          end
        end
        default: begin
          pending_next = pending;
        end
      endcase
    end else begin
      // Reset wins over clock sleep
      if (control_word[ddsri_pkg::CW_RESET]) begin
        acc_next    = '0;
        toggle_base = 1'b0;
      end else if (!control_word[ddsri_pkg::CW_SLEEP1]) begin
        acc_next = acc + ACC_BITS'(freq[control_word[ddsri_pkg::CW_FSEL]]);
      end
      msb_next      = acc_next[ACC_BITS-1];
      toggle_next   = toggle_base ^ (prev_msb & ~msb_next);
      prev_msb_next = msb_next;
    end
  end

  always_comb begin
    psel     = control_word_next[ddsri_pkg::CW_PSEL];
    top_bits = acc_next[ACC_BITS-1 -: PHASE_BITS];
    offset   = phase_next[psel][ddsri_pkg::PHASE_REG_BITS-1 -: PHASE_BITS];
    index    = top_bits + offset;

    res.phase_index = ddsri_pkg::INDEX_BITS'(index);
    if (control_word_next[ddsri_pkg::CW_OPBITEN]) begin
      res.wave_mode = control_word_next[ddsri_pkg::CW_DIV2] ? ddsri_pkg::WAVE_SQUARE_MSB
                                                            : ddsri_pkg::WAVE_SQUARE_HALF;
    end else begin
      res.wave_mode = control_word_next[ddsri_pkg::CW_MODE] ? ddsri_pkg::WAVE_TRIANGLE
                                                            : ddsri_pkg::WAVE_SINE;
    end
    res.square_level = control_word_next[ddsri_pkg::CW_DIV2] ? acc_next[ACC_BITS-1]
                                                             : toggle_next;
    res.dac_enabled  = ~control_word_next[ddsri_pkg::CW_SLEEP12];
    res.running      = ~(control_word_next[ddsri_pkg::CW_RESET] |
                         control_word_next[ddsri_pkg::CW_SLEEP1]);
  end

endmodule

### design/ddsri_out_stage.sv
// ----------------------------------------------------------------------------
// ddsri_out_stage
// Result register; holds a result until the sink takes the transaction.
// ----------------------------------------------------------------------------
module ddsri_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic               ready,
  input  ddsri_pkg::result_t res_d,
  output logic               valid,
  output ddsri_pkg::result_t res
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_d;
    end
  end

endmodule

### design/dds_register_interface_unit.sv
// ----------------------------------------------------------------------------
// dds_register_interface_unit
// Serial word register interface and phase accumulator of a 28-bit DDS.
// ----------------------------------------------------------------------------
// Each request transaction is either a 16-bit serial word or one master clock
// tick, and each produces exactly one status result reflecting the state after
// it. A transaction passes an input register, the register file and
// accumulator update, and a result register, one transaction taken every
// cycle while the result side keeps up. The accumulator add feeds the phase
// offset add combinationally. Request ready drops only while both registers
// are full and the result is not being taken.
module dds_register_interface_unit #(
  parameter int ACC_BITS   = 28,
  parameter int PHASE_BITS = 12
) (
  input logic         clk,
  input logic         rst,
  ddsri_req_if.sink   request,
  ddsri_res_if.source result
);

  ddsri_pkg::item_t   item_d, item;
  ddsri_pkg::result_t res_d, res;
  logic               item_valid;
  logic               out_valid;
  logic               advance;
  logic               load;
  logic               step;

  assign advance       = ~out_valid | result.ready;
  assign request.ready = ~item_valid | advance;
  assign load          = request.valid & request.ready;
  assign step          = item_valid & advance;
  assign item_d.cmd    = request.cmd;
  assign item_d.word   = request.word;

  ddsri_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .advance (advance),
    .item_d  (item_d),
    .valid   (item_valid),
    .item    (item)
  );

  ddsri_core #(
    .ACC_BITS   (ACC_BITS),
    .PHASE_BITS (PHASE_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (item),
    .res  (res_d)
  );

  ddsri_out_stage u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (step),
    .ready (result.ready),
    .res_d (res_d),
    .valid (out_valid),
    .res   (res)
  );

  assign result.valid        = out_valid;
  assign result.phase_index  = res.phase_index;
  assign result.wave_mode    = res.wave_mode;
  assign result.square_level = res.square_level;
  assign result.dac_enabled  = res.dac_enabled;
  assign result.running      = res.running;

endmodule

### design/ddsri_checker.sv
// ----------------------------------------------------------------------------
// ddsri_checker
// Port-level checks on the register interface unit, bound to the top level.
// ----------------------------------------------------------------------------
module ddsri_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             req_ready,
  input logic                             res_valid,
  input logic                             res_ready,
  input logic [ddsri_pkg::INDEX_BITS-1:0] res_phase_index,
  input logic [ddsri_pkg::MODE_BITS-1:0]  res_wave_mode,
  input logic                             res_square_level,
  input logic                             res_dac_enabled,
  input logic                             res_running
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> (res_valid && !res_ready))
    else $error("request stalled without a stalled result");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("result dropped before transaction");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> ($stable(res_phase_index) && $stable(res_wave_mode) &&
      $stable(res_square_level) && $stable(res_dac_enabled) && $stable(res_running)))
    else $error("result changed while stalled");

endmodule

bind dds_register_interface_unit ddsri_checker u_ddsri_checker (
  .clk              (clk),
  .rst              (rst),
  .req_ready        (request.ready),
  .res_valid        (result.valid),
  .res_ready        (result.ready),
  .res_phase_index  (result.phase_index),
  .res_wave_mode    (result.wave_mode),
  .res_square_level (result.square_level),
  .res_dac_enabled  (result.dac_enabled),
  .res_running      (result.running)
);
